### rtl/gwm_pkg.sv
// shared constants, types and register codes for the glob name matcher
`timescale 1ns / 1ps
`default_nettype none

package gwm_pkg;

    localparam int MAX_CHARS    = 32;
    localparam int POS_W        = MAX_CHARS + 1;
    localparam int LEN_W        = $clog2(MAX_CHARS + 1);
    localparam int CFG_LEN_W    = 6;
    localparam int CFG_DATA_W   = 64;
    localparam int CFG_IDX_W    = 3;
    localparam int PAT_REGS     = 4;
    localparam int PAT_IDX_W    = $clog2(PAT_REGS);
    localparam int PAT_W        = PAT_REGS * CFG_DATA_W;
    localparam int CHAR_W       = 8;
    localparam int CLOSE_ROUNDS = $clog2(POS_W);
    localparam int Q_DEPTH      = 2;
    localparam int Q_PTR_W      = $clog2(Q_DEPTH);
    localparam int Q_CNT_W      = $clog2(Q_DEPTH + 1);

    localparam logic [CHAR_W-1:0] STAR_CHAR  = 8'h2A;
    localparam logic [CHAR_W-1:0] QMARK_CHAR = 8'h3F;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_PAT_0 = 3'd0,
        REG_PAT_1 = 3'd1,
        REG_PAT_2 = 3'd2,
        REG_PAT_3 = 3'd3,
        REG_LEN   = 3'd4,
        REG_WILD  = 3'd5
    } reg_idx_t;

    typedef struct packed {
        logic [PAT_W-1:0] pattern;
        logic [LEN_W-1:0] used_len;
        logic             wild;
    } cfg_t;

    typedef struct packed {
        logic [MAX_CHARS-1:0] hit;
        logic                 present;
        logic                 last;
    } item_t;

endpackage

`default_nettype wire

### rtl/gwm_front.sv
// front end: takes name bytes and turns each into a per-position hit vector
`timescale 1ns / 1ps
`default_nettype none

module gwm_front (
    input  wire gwm_pkg::cfg_t                  cfg,
    input  wire logic                           s_valid,
    output logic                                s_ready,
    input  wire logic [gwm_pkg::CHAR_W-1:0]     s_name_byte,
    input  wire logic                           s_byte_present,
    input  wire logic                           s_end_of_name,
    input  wire logic                           q_full,
    output logic                                q_push,
    output gwm_pkg::item_t                      q_item
);

    logic [gwm_pkg::MAX_CHARS-1:0] hit;
    logic [gwm_pkg::CHAR_W-1:0]    pc;
    logic                          in_use;

    always_comb begin
        hit = '0;
        for (int i = 0; i < gwm_pkg::MAX_CHARS; i++) begin
            pc     = cfg.pattern[i*gwm_pkg::CHAR_W +: gwm_pkg::CHAR_W];
            in_use = gwm_pkg::LEN_W'(i) < cfg.used_len;
            // a wildcard star never consumes a byte by moving forward
            hit[i] = s_byte_present && in_use
                     && !(cfg.wild && pc == gwm_pkg::STAR_CHAR)
                     && ((cfg.wild && pc == gwm_pkg::QMARK_CHAR) || pc == s_name_byte);
        end
    end

    assign s_ready        = !q_full;
    assign q_push         = s_valid && !q_full;
    assign q_item.hit     = hit;
    assign q_item.present = s_byte_present;
    assign q_item.last    = s_end_of_name;

endmodule

`default_nettype wire

### rtl/gwm_queue.sv
// short fifo between front and back
`timescale 1ns / 1ps
`default_nettype none

module gwm_queue (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  wire logic                         push,
    input  wire gwm_pkg::item_t               push_item,
    output logic                              full,
    input  wire logic                         pop,
    output logic                              q_valid,
    output gwm_pkg::item_t                    q_item,
    output logic [gwm_pkg::Q_CNT_W-1:0]       count
);

    gwm_pkg::item_t                  mem_reg [gwm_pkg::Q_DEPTH];
    logic [gwm_pkg::Q_PTR_W-1:0]     wr_ptr_reg, wr_ptr_next;
    logic [gwm_pkg::Q_PTR_W-1:0]     rd_ptr_reg, rd_ptr_next;
    logic [gwm_pkg::Q_CNT_W-1:0]     count_reg, count_next;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == gwm_pkg::Q_PTR_W'(gwm_pkg::Q_DEPTH - 1))
                          ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == gwm_pkg::Q_PTR_W'(gwm_pkg::Q_DEPTH - 1))
                          ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= push_item;
        end
    end

    assign full    = count_reg == gwm_pkg::Q_CNT_W'(gwm_pkg::Q_DEPTH);
    assign q_valid = count_reg != '0;
    assign q_item  = mem_reg[rd_ptr_reg];
    assign count   = count_reg;

endmodule

`default_nettype wire

### rtl/gwm_back.sv
// back end: active position set update, final star closure and result register
`timescale 1ns / 1ps
`default_nettype none

module gwm_back (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire gwm_pkg::cfg_t     cfg,
    input  wire logic              q_valid,
    input  wire gwm_pkg::item_t    q_item,
    output logic                   q_pop,
    output logic                   m_valid,
    input  wire logic              m_ready,
    output logic                   m_name_matched
);

    // prefix propagation of active positions across runs of stars
    function automatic logic [gwm_pkg::POS_W-1:0] star_closure(
        input logic [gwm_pkg::POS_W-1:0]     set_in,
        input logic [gwm_pkg::MAX_CHARS-1:0] star
    );
        logic [gwm_pkg::POS_W-1:0] g;
        logic [gwm_pkg::POS_W-1:0] p;
        g = set_in;
        p = {star, 1'b0};
        for (int k = 0; k < gwm_pkg::CLOSE_ROUNDS; k++) begin
            g = g | ((g << (1 << k)) & p);
            p = p & (p << (1 << k));
        end
        return g;
    endfunction

    logic [gwm_pkg::POS_W-1:0]     set_reg, set_next;
    logic [gwm_pkg::POS_W-1:0]     fin_set_reg;
    logic                          fin_valid_reg;
    logic                          m_valid_reg;
    logic                          m_name_matched_reg;
    logic [gwm_pkg::MAX_CHARS-1:0] star;
    logic [gwm_pkg::POS_W-1:0]     cur;
    logic [gwm_pkg::POS_W-1:0]     adv;
    logic [gwm_pkg::POS_W-1:0]     fin_closed;
    logic                          out_free;
    logic                          fin_free;
    logic                          fin_move;

    always_comb begin
        for (int i = 0; i < gwm_pkg::MAX_CHARS; i++) begin
            star[i] = cfg.wild && (gwm_pkg::LEN_W'(i) < cfg.used_len)
                      && cfg.pattern[i*gwm_pkg::CHAR_W +: gwm_pkg::CHAR_W] == gwm_pkg::STAR_CHAR;
        end
    end

    always_comb begin
        cur = star_closure(set_reg, star);
        // a star keeps its position, a hit moves one position on
        adv = {1'b0, cur[gwm_pkg::MAX_CHARS-1:0] & star}
            | {cur[gwm_pkg::MAX_CHARS-1:0] & q_item.hit, 1'b0};
        set_next   = q_item.present ? adv : cur;
        fin_closed = star_closure(fin_set_reg, star);
    end

    assign out_free = !m_valid_reg || m_ready;
    assign fin_free = !fin_valid_reg || out_free;
    assign fin_move = fin_valid_reg && out_free;
    assign q_pop    = q_valid && (!q_item.last || fin_free);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            set_reg       <= gwm_pkg::POS_W'(1);
            fin_valid_reg <= 1'b0;
            m_valid_reg   <= 1'b0;
        end else begin
            if (q_pop) begin
                set_reg <= q_item.last ? gwm_pkg::POS_W'(1) : set_next;
            end
            if (q_pop && q_item.last) begin
                fin_valid_reg <= 1'b1;
            end else if (fin_move) begin
                fin_valid_reg <= 1'b0;
            end
            if (fin_move) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (q_pop && q_item.last) begin
            fin_set_reg <= set_next;
        end
        if (fin_move) begin
            m_name_matched_reg <= fin_closed[cfg.used_len];
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_name_matched = m_name_matched_reg;

endmodule

`default_nettype wire

### rtl/glob_wildcard_name_matcher.sv
// top level of the glob name matcher: config registers, front, queue and back
//
// Names stream in one byte per transfer and the block sustains one transfer per
// clock while the queue is not full; result back-pressure can fill it. The bound
// is the set update in the back end, one star closure plus one advance of the
// 33-position active set per cycle. A name's result passes the queue, the final
// set register (set update) and the output register (final star closure).
// Pattern registers may be written only between names or while no item is in
// flight; there is no clearing pass after reset.
`timescale 1ns / 1ps
`default_nettype none

module glob_wildcard_name_matcher (
    input  wire logic                               aclk,
    input  wire logic                               aresetn,
    input  wire logic                               cfg_valid,
    output logic                                    cfg_ready,
    input  wire logic [gwm_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  wire logic [gwm_pkg::CFG_DATA_W-1:0]     cfg_data,
    input  wire logic                               s_valid,
    output logic                                    s_ready,
    input  wire logic [gwm_pkg::CHAR_W-1:0]         s_name_byte,
    input  wire logic                               s_byte_present,
    input  wire logic                               s_end_of_name,
    output logic                                    m_valid,
    input  wire logic                               m_ready,
    output logic                                    m_name_matched
);

    logic [gwm_pkg::CFG_DATA_W-1:0] pattern_reg [gwm_pkg::PAT_REGS];
    logic [gwm_pkg::CFG_LEN_W-1:0]  len_reg;
    logic                           wild_reg;
    gwm_pkg::cfg_t                  cfg;
    gwm_pkg::item_t                 push_item;
    gwm_pkg::item_t                 q_item;
    logic                           q_push;
    logic                           q_pop;
    logic                           q_full;
    logic                           q_valid;
    logic [gwm_pkg::Q_CNT_W-1:0]    q_count;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int k = 0; k < gwm_pkg::PAT_REGS; k++) begin
                pattern_reg[k] <= '0;
            end
            len_reg  <= '0;
            wild_reg <= 1'b1;
        end else if (cfg_valid) begin
            unique case (cfg_index) inside
                gwm_pkg::REG_PAT_0, gwm_pkg::REG_PAT_1,
                gwm_pkg::REG_PAT_2, gwm_pkg::REG_PAT_3: begin
                    pattern_reg[cfg_index[gwm_pkg::PAT_IDX_W-1:0]] <= cfg_data;
                end
                gwm_pkg::REG_LEN: begin
                    len_reg <= cfg_data[gwm_pkg::CFG_LEN_W-1:0];
                end
                gwm_pkg::REG_WILD: begin
                    wild_reg <= cfg_data[0];
                end
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        for (int k = 0; k < gwm_pkg::PAT_REGS; k++) begin
            cfg.pattern[k*gwm_pkg::CFG_DATA_W +: gwm_pkg::CFG_DATA_W] = pattern_reg[k];
        end
        // lengths beyond the pattern store saturate
        if (len_reg > gwm_pkg::CFG_LEN_W'(gwm_pkg::MAX_CHARS)) begin
            cfg.used_len = gwm_pkg::LEN_W'(gwm_pkg::MAX_CHARS);
        end else begin
            cfg.used_len = gwm_pkg::LEN_W'(len_reg);
        end
        cfg.wild = wild_reg;
    end

    gwm_front u_front (
        .cfg            (cfg),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_name_byte    (s_name_byte),
        .s_byte_present (s_byte_present),
        .s_end_of_name  (s_end_of_name),
        .q_full         (q_full),
        .q_push         (q_push),
        .q_item         (push_item)
    );

    gwm_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_item (push_item),
        .full      (q_full),
        .pop       (q_pop),
        .q_valid   (q_valid),
        .q_item    (q_item),
        .count     (q_count)
    );

    gwm_back u_back (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg            (cfg),
        .q_valid        (q_valid),
        .q_item         (q_item),
        .q_pop          (q_pop),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_name_matched (m_name_matched)
    );

`ifndef SYNTHESIS
    a_no_result_after_reset: assert property (@(posedge aclk) disable iff (!aresetn)
        $past(!aresetn) |-> !m_valid)
        else $error("result valid right after reset");

    a_pop_needs_entry: assert property (@(posedge aclk) disable iff (!aresetn)
        q_pop |-> q_count != '0)
        else $error("queue popped while empty");

    a_count_tracks_push: assert property (@(posedge aclk) disable iff (!aresetn)
        (q_push && !q_pop) |=> q_count == gwm_pkg::Q_CNT_W'($past(q_count) + 1'b1))
        else $error("queue count lost a transfer");
`endif

endmodule

`default_nettype wire

### bench/gwm_checker.sv
// checker for the glob name matcher: tracks config, predicts each name's verdict, compares
`timescale 1ns / 1ps

module gwm_checker (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire logic                           cfg_valid,
    input  wire logic                           cfg_ready,
    input  wire logic [gwm_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [gwm_pkg::CFG_DATA_W-1:0] cfg_data,
    input  wire logic                           s_valid,
    input  wire logic                           s_ready,
    input  wire logic [gwm_pkg::CHAR_W-1:0]     s_name_byte,
    input  wire logic                           s_byte_present,
    input  wire logic                           s_end_of_name,
    input  wire logic                           m_valid,
    input  wire logic                           m_ready,
    input  wire logic                           m_name_matched,
    output int                                  mismatch_count,
    output int                                  open_names
);

    logic [gwm_pkg::CFG_DATA_W-1:0] pat_regs [gwm_pkg::PAT_REGS];
    logic [gwm_pkg::CFG_LEN_W-1:0]  pat_len;
    logic                           wild;
    logic [gwm_pkg::POS_W-1:0]      live_set;
    logic [gwm_pkg::POS_W-1:0]      work;
    logic                           verdict_q [$];
    logic                           want;

    function automatic int used_chars();
        return (pat_len > gwm_pkg::MAX_CHARS) ? gwm_pkg::MAX_CHARS : int'(pat_len);
    endfunction

    function automatic logic [gwm_pkg::CHAR_W-1:0] pat_char(int i);
        return pat_regs[i / 8][(i % 8) * gwm_pkg::CHAR_W +: gwm_pkg::CHAR_W];
    endfunction

    // a live star also makes the position after it live
    function automatic logic [gwm_pkg::POS_W-1:0] close_stars(
        logic [gwm_pkg::POS_W-1:0] set);
        logic [gwm_pkg::POS_W-1:0] s;
        int                        i;
        s = set;
        if (wild) begin
            for (i = 0; i < used_chars(); i++)
                if (s[i] && pat_char(i) == gwm_pkg::STAR_CHAR)
                    s[i + 1] = 1'b1;
        end
        return s;
    endfunction

    function automatic logic [gwm_pkg::POS_W-1:0] eat_byte(
        logic [gwm_pkg::POS_W-1:0] set, logic [gwm_pkg::CHAR_W-1:0] b);
        logic [gwm_pkg::POS_W-1:0]  nxt;
        logic [gwm_pkg::CHAR_W-1:0] c;
        int                         i;
        nxt = '0;
        for (i = 0; i < used_chars(); i++) begin
            if (set[i]) begin
                c = pat_char(i);
                if (wild && c == gwm_pkg::STAR_CHAR)
                    nxt[i] = 1'b1;
                else if ((wild && c == gwm_pkg::QMARK_CHAR) || c == b)
                    nxt[i + 1] = 1'b1;
            end
        end
        return nxt;
    endfunction

    task automatic report_mismatch(input string what);
        $display("mismatch at %0t ns: %s", $time, what);
        mismatch_count++;
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            foreach (pat_regs[r])
                pat_regs[r] = '0;
            pat_len = '0;
            wild = 1'b1;
            live_set = gwm_pkg::POS_W'(1);
            verdict_q.delete();
            mismatch_count = 0;
        end else begin
            if (s_valid && s_ready) begin
                work = close_stars(live_set);
                if (s_byte_present)
                    work = eat_byte(work, s_name_byte);
                if (s_end_of_name) begin
                    work = close_stars(work);
                    verdict_q = {verdict_q, work[used_chars()]};
                    live_set = gwm_pkg::POS_W'(1);
                end else begin
                    live_set = work;
                end
            end
            if (m_valid && m_ready) begin
                if (verdict_q.size() == 0) begin
                    report_mismatch("result transfer with no name pending");
                end else begin
                    want = verdict_q.pop_front();
                    if (m_name_matched !== want)
                        report_mismatch($sformatf("name_matched got %0b, expected %0b",
                                                  m_name_matched, want));
                end
            end
            // config takes effect from the next item
            if (cfg_valid && cfg_ready) begin
                case (cfg_index) inside
                    gwm_pkg::REG_PAT_0, gwm_pkg::REG_PAT_1,
                    gwm_pkg::REG_PAT_2, gwm_pkg::REG_PAT_3:
                        pat_regs[cfg_index[gwm_pkg::PAT_IDX_W-1:0]] = cfg_data;
                    gwm_pkg::REG_LEN:  pat_len = cfg_data[gwm_pkg::CFG_LEN_W-1:0];
                    gwm_pkg::REG_WILD: wild = cfg_data[0];
                    default: ;
                endcase
            end
        end
        open_names = verdict_q.size();
    end

endmodule

### bench/testbench.sv
// testbench top for the glob name matcher: clock, reset, stimulus and verdict
`timescale 1ns / 1ps

module testbench;

    logic                           aclk;
    logic                           aresetn;
    logic                           cfg_valid;
    logic                           cfg_ready;
    logic [gwm_pkg::CFG_IDX_W-1:0]  cfg_index;
    logic [gwm_pkg::CFG_DATA_W-1:0] cfg_data;
    logic                           s_valid;
    logic                           s_ready;
    logic [gwm_pkg::CHAR_W-1:0]     s_name_byte;
    logic                           s_byte_present;
    logic                           s_end_of_name;
    logic                           m_valid;
    logic                           m_ready;
    logic                           m_name_matched;
    int                             mismatch_count;
    int                             open_names;

    bit                             idle_on;
    bit                             noise_on;
    bit                             hold_req;
    int                             sent_items;
    logic [gwm_pkg::CHAR_W-1:0]     pat_chars [gwm_pkg::MAX_CHARS];
    logic [gwm_pkg::CFG_LEN_W-1:0]  pat_len_reg;
    logic                           wild_reg;
    logic [gwm_pkg::CHAR_W-1:0]     name_q [$];

    glob_wildcard_name_matcher i_dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_name_byte    (s_name_byte),
        .s_byte_present (s_byte_present),
        .s_end_of_name  (s_end_of_name),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_name_matched (m_name_matched)
    );

    gwm_checker i_checker (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_name_byte    (s_name_byte),
        .s_byte_present (s_byte_present),
        .s_end_of_name  (s_end_of_name),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_name_matched (m_name_matched),
        .mismatch_count (mismatch_count),
        .open_names     (open_names)
    );

    always begin
        aclk = 1'b0;
        #5;
        aclk = 1'b1;
        #5;
    end

    initial begin
        #2_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

    // result side: random back-pressure, plus one long hold-off on request
    initial begin : result_sink
        m_ready = 1'b0;
        forever begin
            @(posedge aclk);
            if (hold_req) begin
                hold_req = 1'b0;
                m_ready <= 1'b0;
                repeat (300) @(posedge aclk);
            end
            m_ready <= !(idle_on && $urandom_range(0, 99) < 9);
        end
    end

    function automatic int used_len(logic [gwm_pkg::CFG_LEN_W-1:0] l);
        return (l > gwm_pkg::MAX_CHARS) ? gwm_pkg::MAX_CHARS : int'(l);
    endfunction

    function automatic logic [gwm_pkg::CHAR_W-1:0] pick_char();
        case ($urandom_range(0, 5))
            0: return 8'h61;
            1: return 8'h62;
            2: return 8'h63;
            3: return gwm_pkg::STAR_CHAR;
            4: return gwm_pkg::QMARK_CHAR;
            default: return gwm_pkg::CHAR_W'($urandom_range(0, 255));
        endcase
    endfunction

    function automatic logic [gwm_pkg::CHAR_W-1:0] pick_pat_char();
        int r;
        r = $urandom_range(0, 99);
        if (r < 20)
            return gwm_pkg::STAR_CHAR;
        else if (r < 35)
            return gwm_pkg::QMARK_CHAR;
        else if (r < 85)
            return gwm_pkg::CHAR_W'(8'h61 + $urandom_range(0, 2));
        return gwm_pkg::CHAR_W'($urandom_range(0, 255));
    endfunction

    function automatic logic [gwm_pkg::CFG_DATA_W-1:0] pat_word(int r);
        logic [gwm_pkg::CFG_DATA_W-1:0] w;
        int                             b;
        for (b = 0; b < 8; b++)
            w[b * gwm_pkg::CHAR_W +: gwm_pkg::CHAR_W] = pat_chars[r * 8 + b];
        return w;
    endfunction

    task automatic cfg_write(input gwm_pkg::reg_idx_t idx,
                             input logic [gwm_pkg::CFG_DATA_W-1:0] data);
        @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do
            @(posedge aclk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    task automatic write_config();
        logic [gwm_pkg::CFG_DATA_W-1:0] d;
        cfg_write(gwm_pkg::REG_PAT_0, pat_word(0));
        cfg_write(gwm_pkg::REG_PAT_1, pat_word(1));
        cfg_write(gwm_pkg::REG_PAT_2, pat_word(2));
        cfg_write(gwm_pkg::REG_PAT_3, pat_word(3));
        // junk in the unused upper bits must be ignored
        d = {$urandom(), $urandom()};
        d[gwm_pkg::CFG_LEN_W-1:0] = pat_len_reg;
        cfg_write(gwm_pkg::REG_LEN, d);
        d = {$urandom(), $urandom()};
        d[0] = wild_reg;
        cfg_write(gwm_pkg::REG_WILD, d);
    endtask

    task automatic load_pattern(input string s, input int len_val, input bit w);
        int k;
        for (k = 0; k < gwm_pkg::MAX_CHARS; k++)
            pat_chars[k] = (k < s.len()) ? gwm_pkg::CHAR_W'(s[k]) : '0;
        pat_len_reg = gwm_pkg::CFG_LEN_W'(len_val);
        wild_reg = w;
    endtask

    // called at a clock edge; returns at the edge where the item transfers
    task automatic send_item(input logic [gwm_pkg::CHAR_W-1:0] b, input logic p,
                             input logic e);
        while (idle_on && $urandom_range(0, 99) < 9) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid        <= 1'b1;
        s_name_byte    <= b;
        s_byte_present <= p;
        s_end_of_name  <= e;
        do
            @(posedge aclk);
        while (!s_ready);
        if (p || e)
            sent_items++;
    endtask

    task automatic send_name();
        bit tail;
        int i;
        tail = (name_q.size() == 0) || (noise_on && $urandom_range(0, 9) == 0);
        for (i = 0; i < name_q.size(); i++) begin
            if (noise_on && $urandom_range(0, 99) < 4)
                send_item(gwm_pkg::CHAR_W'($urandom_range(0, 255)), 1'b0, 1'b0);
            send_item(name_q[i], 1'b1, (i == name_q.size() - 1) && !tail);
        end
        if (tail)
            send_item(gwm_pkg::CHAR_W'($urandom_range(0, 255)), 1'b0, 1'b1);
    endtask

    // mostly names built to fit the pattern, some mutated, some pure noise
    task automatic make_name();
        int                         kind;
        int                         k;
        logic [gwm_pkg::CHAR_W-1:0] c;
        name_q.delete();
        kind = $urandom_range(0, 99);
        if (kind < 65) begin
            for (k = 0; k < used_len(pat_len_reg); k++) begin
                c = pat_chars[k];
                if (wild_reg && c == gwm_pkg::STAR_CHAR)
                    repeat ($urandom_range(0, 3)) name_q = {name_q, pick_char()};
                else if (wild_reg && c == gwm_pkg::QMARK_CHAR)
                    name_q = {name_q, gwm_pkg::CHAR_W'($urandom_range(0, 255))};
                else
                    name_q = {name_q, c};
            end
            if (name_q.size() > 0 && $urandom_range(0, 3) == 0)
                name_q[$urandom_range(0, name_q.size() - 1)] = pick_char();
            if (name_q.size() > 0 && $urandom_range(0, 9) == 0)
                name_q.delete(name_q.size() - 1);
        end else if (kind < 90) begin
            repeat ($urandom_range(0, 6)) name_q = {name_q, pick_char()};
        end else begin
            repeat ($urandom_range(0, 12))
                name_q = {name_q, gwm_pkg::CHAR_W'($urandom_range(0, 255))};
        end
    endtask

    // stop sending and wait until every pending name has its result
    task automatic settle();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (open_names != 0)
            @(posedge aclk);
        repeat (8) @(posedge aclk);
    endtask

    initial begin : stimulus
        int phase;
        int k;
        int goal;
        aresetn        = 1'b0;
        cfg_valid      = 1'b0;
        cfg_index      = '0;
        cfg_data       = '0;
        s_valid        = 1'b0;
        s_name_byte    = '0;
        s_byte_present = 1'b0;
        s_end_of_name  = 1'b0;
        idle_on        = 1'b1;
        noise_on       = 1'b0;
        hold_req       = 1'b0;
        sent_items     = 0;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;

        // reset config: empty pattern, wildcards on
        send_item(8'h00, 1'b0, 1'b1);
        send_item(8'hFF, 1'b1, 1'b1);
        send_item(8'hA5, 1'b0, 1'b0);
        send_item(8'h5A, 1'b0, 1'b1);

        // wildcards with a zero byte in pattern and name
        settle();
        load_pattern("*a?", 4, 1'b1);
        write_config();
        name_q = '{8'h78, 8'h61, 8'hFF, 8'h00};
        send_name();
        name_q = '{8'h61, 8'h00};
        send_name();

        // same pattern compared literally
        settle();
        wild_reg = 1'b0;
        write_config();
        name_q = '{gwm_pkg::STAR_CHAR, 8'h61, gwm_pkg::QMARK_CHAR, 8'h00};
        send_name();
        name_q = '{8'h78};
        send_name();

        // oversized length clamps to the full 32 characters
        settle();
        for (k = 0; k < gwm_pkg::MAX_CHARS - 1; k++)
            pat_chars[k] = gwm_pkg::STAR_CHAR;
        pat_chars[gwm_pkg::MAX_CHARS - 1] = 8'h7A;
        pat_len_reg = 6'd63;
        wild_reg = 1'b1;
        write_config();
        name_q = '{8'h7A};
        send_name();
        name_q = '{8'h71};
        send_name();
        send_item(8'h00, 1'b0, 1'b1);

        // pattern changed while a name is half done
        settle();
        load_pattern("ab", 2, 1'b1);
        write_config();
        send_item(8'h61, 1'b1, 1'b0);
        settle();
        pat_chars[1] = 8'h63;
        cfg_write(gwm_pkg::REG_PAT_0, pat_word(0));
        send_item(8'h63, 1'b1, 1'b1);

        for (phase = 0; phase < 10; phase++) begin
            settle();
            idle_on = (phase != 4);
            noise_on = 1'b1;
            wild_reg = (phase % 4 == 3) ? 1'b0 : 1'b1;
            case (phase)
                0:       pat_len_reg = '0;
                1:       pat_len_reg = gwm_pkg::CFG_LEN_W'(gwm_pkg::MAX_CHARS);
                2:       pat_len_reg = gwm_pkg::CFG_LEN_W'(
                                           $urandom_range(gwm_pkg::MAX_CHARS + 1, 63));
                default: pat_len_reg = gwm_pkg::CFG_LEN_W'($urandom_range(1, 8));
            endcase
            for (k = 0; k < gwm_pkg::MAX_CHARS; k++) begin
                if (phase == 0)
                    pat_chars[k] = 8'hFF;
                else if (k < used_len(pat_len_reg))
                    pat_chars[k] = pick_pat_char();
                else
                    pat_chars[k] = gwm_pkg::CHAR_W'($urandom_range(0, 255));
            end
            write_config();
            if (phase == 6)
                hold_req = 1'b1;
            goal = sent_items + 95;
            while (sent_items < goal) begin
                make_name();
                send_name();
            end
        end

        settle();
        if (mismatch_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

### sim.f
rtl/gwm_pkg.sv
rtl/gwm_front.sv
rtl/gwm_queue.sv
rtl/gwm_back.sv
rtl/glob_wildcard_name_matcher.sv
bench/gwm_checker.sv
bench/testbench.sv
